### hw/rtl/srfpll_pkg.sv
package srfpll_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ANGLE_W    = 16;
   localparam int ACC_W      = 24;
   localparam int GAIN_W     = 24;
   localparam int FREQ_W     = 32;
   localparam int MUL_A_W    = 34;
   localparam int MUL_B_W    = 18;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 8 * SAMPLE_W;
   localparam int RSP_DATA_W = 11 * SAMPLE_W + FREQ_W;
   localparam int STEP_W     = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLL_KP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PLL_KI_TS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_SC  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LPF_ALPHA = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VSG_KP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_VSG_KI_TS = 3'd6;

   localparam logic [15:0]       LPF_ALPHA_RST = 16'd655;
   localparam logic [GAIN_W-1:0] VSG_KP_RST    = 24'd117965;

   localparam int INV3_Q16     = 21845;
   localparam int INVSQRT3_Q16 = 37837;
   localparam int SIN_A1       = 102944;
   localparam int SIN_A3       = 42048;
   localparam int SIN_A5       = 4640;

   // sequencer steps, one multiply each
   localparam logic [STEP_W-1:0] S_CLK_AV  = 5'd0;
   localparam logic [STEP_W-1:0] S_CLK_BV  = 5'd1;
   localparam logic [STEP_W-1:0] S_CLK_AI  = 5'd2;
   localparam logic [STEP_W-1:0] S_CLK_BI  = 5'd3;
   localparam logic [STEP_W-1:0] S_SIN0_Z  = 5'd4;
   localparam logic [STEP_W-1:0] S_SIN0_A5 = 5'd5;
   localparam logic [STEP_W-1:0] S_SIN0_A3 = 5'd6;
   localparam logic [STEP_W-1:0] S_SIN0_A1 = 5'd7;
   localparam logic [STEP_W-1:0] S_SIN1_Z  = 5'd8;
   localparam logic [STEP_W-1:0] S_SIN1_A5 = 5'd9;
   localparam logic [STEP_W-1:0] S_SIN1_A3 = 5'd10;
   localparam logic [STEP_W-1:0] S_SIN1_A1 = 5'd11;
   localparam logic [STEP_W-1:0] S_DV_A    = 5'd12;
   localparam logic [STEP_W-1:0] S_DV_B    = 5'd13;
   localparam logic [STEP_W-1:0] S_QV_A    = 5'd14;
   localparam logic [STEP_W-1:0] S_QV_B    = 5'd15;
   localparam logic [STEP_W-1:0] S_DI_A    = 5'd16;
   localparam logic [STEP_W-1:0] S_DI_B    = 5'd17;
   localparam logic [STEP_W-1:0] S_QI_A    = 5'd18;
   localparam logic [STEP_W-1:0] S_QI_B    = 5'd19;
   localparam logic [STEP_W-1:0] S_OMEGA   = 5'd20;
   localparam logic [STEP_W-1:0] S_INTEG   = 5'd21;
   localparam logic [STEP_W-1:0] S_LPF     = 5'd22;
   localparam logic [STEP_W-1:0] S_PHASE   = 5'd23;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              mode;
      logic [GAIN_W-1:0] pll_kp;
      logic [GAIN_W-1:0] pll_ki_ts;
      logic [15:0]       phase_step_scale;
      logic [15:0]       lpf_alpha;
      logic [GAIN_W-1:0] vsg_kp;
      logic [GAIN_W-1:0] vsg_ki_ts;
   } cfg_type;

   // add one half, then floor
   function automatic logic signed [MUL_P_W-1:0] rshr(input logic signed [MUL_P_W-1:0] v,
                                                       input int unsigned n);
      logic signed [MUL_P_W-1:0] half;
      logic signed [MUL_P_W-1:0] sum;
      half = MUL_P_W'(64'd1 << (n - 1));
      sum  = v + half;
      return sum >>> n;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [MUL_P_W-1:0] v);
      if (v > 52'sd32767) begin
         return 16'sh7fff;
      end else if (v < -52'sd32768) begin
         return 16'sh8000;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [FREQ_W-1:0] sat32(input logic signed [MUL_P_W-1:0] v);
      if (v > 52'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -52'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[FREQ_W-1:0];
   endfunction

endpackage

### hw/rtl/srfpll_mul.sv
module srfpll_mul (
   input  logic                                  clock,
   input  logic signed [srfpll_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [srfpll_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [srfpll_pkg::MUL_P_W-1:0] prod_ff
);
   import srfpll_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

### hw/rtl/srfpll_csr.sv
module srfpll_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [srfpll_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srfpll_pkg::CSR_DATA_W-1:0]   csr_data,
   output srfpll_pkg::cfg_type                 cfg_ff
);
   import srfpll_pkg::*;

   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE:      cfg_in.mode             = csr_data[0];
            REG_PLL_KP:    cfg_in.pll_kp           = csr_data;
            REG_PLL_KI_TS: cfg_in.pll_ki_ts        = csr_data;
            REG_PHASE_SC:  cfg_in.phase_step_scale = csr_data[15:0];
            REG_LPF_ALPHA: cfg_in.lpf_alpha        = csr_data[15:0];
            REG_VSG_KP:    cfg_in.vsg_kp           = csr_data;
            REG_VSG_KI_TS: cfg_in.vsg_ki_ts        = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode             <= 1'b0;
         cfg_ff.pll_kp           <= '0;
         cfg_ff.pll_ki_ts        <= '0;
         cfg_ff.phase_step_scale <= '0;
         cfg_ff.lpf_alpha        <= LPF_ALPHA_RST;
         cfg_ff.vsg_kp           <= VSG_KP_RST;
         cfg_ff.vsg_ki_ts        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/srf_pll_clarke_park_unit.sv
// channel | ports                          | beat contents
// req     | req_tvalid/tready/tdata/tuser  | three-phase volts, currents, ext sine/cosine; hold
// rsp     | rsp_tvalid/tready/tdata        | alpha/beta, sine/cosine, d/q, angle, freq
// csr     | csr_valid/ready/index/data     | register write, ready whenever out of reset
//
// Each item runs an accept step, then 24 multiplies one after another
// through the single registered multiplier, then a load of the result.
// req_tready is high only while idle and out of reset; a waiting result is held in the
// output register and the block stalls before loading the next one until it is taken.
// Synchronous reset clears control, loop integrator, phase and filter state.
module srf_pll_clarke_park_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // volt_a, volt_b, volt_c, curr_a, curr_b, curr_c, ext_sine, ext_cosine
   input  logic [srfpll_pkg::REQ_DATA_W-1:0]     req_tdata,
   // hold_integrator
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // alpha_volt, beta_volt, alpha_curr, beta_curr, sine_used, cosine_used,
   // d_volt, q_volt, d_curr, q_curr, angle, freq
   output logic [srfpll_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srfpll_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srfpll_pkg::CSR_DATA_W-1:0]     csr_data
);
   import srfpll_pkg::*;

   cfg_type cfg;

   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      phase_ff, phase_in;
   logic [REQ_DATA_W-1:0]     in_data_ff, in_data_in;
   logic                      hold_ff, hold_in;

   logic signed [SAMPLE_W-1:0] alv_ff, alv_in, bev_ff, bev_in, ali_ff, ali_in, bei_ff, bei_in;
   logic signed [SAMPLE_W-1:0] sn_ff, sn_in, cs_ff, cs_in;
   logic signed [SAMPLE_W-1:0] dv_ff, dv_in, qv_ff, qv_in, di_ff, di_in, qi_ff, qi_in;
   logic [14:0]                z2_ff, z2_in, s0_ff, s0_in, s_new;
   logic [16:0]                t_ff, t_in;
   logic signed [MUL_P_W-1:0]  acc_ff, acc_in;
   logic signed [FREQ_W-1:0]   omega_ff, omega_in;
   logic [ANGLE_W-1:0]         ang_ff, ang_in;
   logic signed [FREQ_W-1:0]   vd_int_ff, vd_int_in, freq_filt_ff, freq_filt_in;
   logic [ACC_W-1:0]           phase_acc_ff, phase_acc_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  prod;

   logic signed [SAMPLE_W-1:0] va, vb, vc, ia, ib, ic, ext_sin, ext_cos;
   logic signed [17:0]         cl_av, cl_ai;
   logic signed [16:0]         cl_bv, cl_bi;
   logic [13:0]                r0;
   logic [14:0]                r1;
   logic signed [32:0]         lpf_diff;
   logic [GAIN_W-1:0]          kp_sel, ki_sel;
   logic signed [MUL_P_W-1:0]  y_q15, z_shr;
   logic signed [SAMPLE_W-1:0] s0s, s1s;

   assign va      = in_data_ff[15:0];
   assign vb      = in_data_ff[31:16];
   assign vc      = in_data_ff[47:32];
   assign ia      = in_data_ff[63:48];
   assign ib      = in_data_ff[79:64];
   assign ic      = in_data_ff[95:80];
   assign ext_sin = in_data_ff[111:96];
   assign ext_cos = in_data_ff[127:112];

   assign cl_av    = (18'(va) <<< 1) - 18'(vb) - 18'(vc);
   assign cl_bv    = 17'(vb) - 17'(vc);
   assign cl_ai    = (18'(ia) <<< 1) - 18'(ib) - 18'(ic);
   assign cl_bi    = 17'(ib) - 17'(ic);
   assign r0       = phase_acc_ff[21:8];
   assign r1       = 15'd16384 - {1'b0, r0};
   assign lpf_diff = 33'(omega_ff) - 33'(freq_filt_ff);
   assign kp_sel   = cfg.mode ? cfg.vsg_kp : cfg.pll_kp;
   assign ki_sel   = cfg.mode ? cfg.vsg_ki_ts : cfg.pll_ki_ts;

   assign z_shr = prod >>> 14;
   assign y_q15 = (prod + 52'sd16384) >>> 15;
   assign s_new = (y_q15 > 52'sd32767) ? 15'h7fff : y_q15[14:0];
   assign s0s   = signed'({1'b0, s0_ff});
   assign s1s   = signed'({1'b0, s_new});

   srfpll_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_ff    (cfg)
   );

   srfpll_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   assign csr_ready  = !reset;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand select for the step in hand
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         S_CLK_AV: begin
            mul_a = MUL_A_W'(cl_av);
            mul_b = MUL_B_W'(INV3_Q16);
         end
         S_CLK_BV: begin
            mul_a = MUL_A_W'(cl_bv);
            mul_b = MUL_B_W'(INVSQRT3_Q16);
         end
         S_CLK_AI: begin
            mul_a = MUL_A_W'(cl_ai);
            mul_b = MUL_B_W'(INV3_Q16);
         end
         S_CLK_BI: begin
            mul_a = MUL_A_W'(cl_bi);
            mul_b = MUL_B_W'(INVSQRT3_Q16);
         end
         S_SIN0_Z: begin
            mul_a = MUL_A_W'(signed'({1'b0, r0}));
            mul_b = MUL_B_W'(signed'({1'b0, r0}));
         end
         S_SIN1_Z: begin
            mul_a = MUL_A_W'(signed'({1'b0, r1}));
            mul_b = MUL_B_W'(signed'({1'b0, r1}));
         end
         S_SIN0_A5, S_SIN1_A5: begin
            mul_a = MUL_A_W'(SIN_A5);
            mul_b = MUL_B_W'(signed'({1'b0, z2_ff}));
         end
         S_SIN0_A3, S_SIN1_A3: begin
            mul_a = MUL_A_W'(signed'({1'b0, t_ff}));
            mul_b = MUL_B_W'(signed'({1'b0, z2_ff}));
         end
         S_SIN0_A1: begin
            mul_a = MUL_A_W'(signed'({1'b0, t_ff}));
            mul_b = MUL_B_W'(signed'({1'b0, r0}));
         end
         S_SIN1_A1: begin
            mul_a = MUL_A_W'(signed'({1'b0, t_ff}));
            mul_b = MUL_B_W'(signed'({1'b0, r1}));
         end
         S_DV_A: begin
            mul_a = MUL_A_W'(alv_ff);
            mul_b = MUL_B_W'(cs_ff);
         end
         S_DV_B: begin
            mul_a = MUL_A_W'(bev_ff);
            mul_b = MUL_B_W'(sn_ff);
         end
         S_QV_A: begin
            mul_a = MUL_A_W'(bev_ff);
            mul_b = MUL_B_W'(cs_ff);
         end
         S_QV_B: begin
            mul_a = MUL_A_W'(alv_ff);
            mul_b = MUL_B_W'(sn_ff);
         end
         S_DI_A: begin
            mul_a = MUL_A_W'(ali_ff);
            mul_b = MUL_B_W'(cs_ff);
         end
         S_DI_B: begin
            mul_a = MUL_A_W'(bei_ff);
            mul_b = MUL_B_W'(sn_ff);
         end
         S_QI_A: begin
            mul_a = MUL_A_W'(bei_ff);
            mul_b = MUL_B_W'(cs_ff);
         end
         S_QI_B: begin
            mul_a = MUL_A_W'(ali_ff);
            mul_b = MUL_B_W'(sn_ff);
         end
         S_OMEGA: begin
            mul_a = MUL_A_W'(signed'({1'b0, kp_sel}));
            mul_b = MUL_B_W'(dv_ff);
         end
         S_INTEG: begin
            mul_a = MUL_A_W'(signed'({1'b0, ki_sel}));
            mul_b = MUL_B_W'(dv_ff);
         end
         S_LPF: begin
            mul_a = MUL_A_W'(lpf_diff);
            mul_b = MUL_B_W'(signed'({1'b0, cfg.lpf_alpha}));
         end
         S_PHASE: begin
            mul_a = MUL_A_W'(omega_ff);
            mul_b = MUL_B_W'(signed'({1'b0, cfg.phase_step_scale}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer and result write-back
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      in_data_in   = in_data_ff;
      hold_in      = hold_ff;
      alv_in       = alv_ff;
      bev_in       = bev_ff;
      ali_in       = ali_ff;
      bei_in       = bei_ff;
      sn_in        = sn_ff;
      cs_in        = cs_ff;
      dv_in        = dv_ff;
      qv_in        = qv_ff;
      di_in        = di_ff;
      qi_in        = qi_ff;
      z2_in        = z2_ff;
      t_in         = t_ff;
      s0_in        = s0_ff;
      acc_in       = acc_ff;
      omega_in     = omega_ff;
      ang_in       = ang_ff;
      vd_int_in    = vd_int_ff;
      freq_filt_in = freq_filt_ff;
      phase_acc_in = phase_acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               in_data_in = req_tdata;
               hold_in    = req_tuser;
               state_in   = ST_RUN;
               step_in    = S_CLK_AV;
               phase_in   = 1'b0;
            end
         end
         ST_RUN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               step_in  = step_ff + 5'd1;
               case (step_ff)
                  S_CLK_AV: alv_in = sat16(rshr(prod, 16));
                  S_CLK_BV: bev_in = sat16(rshr(prod, 16));
                  S_CLK_AI: ali_in = sat16(rshr(prod, 16));
                  S_CLK_BI: bei_in = sat16(rshr(prod, 16));
                  S_SIN0_Z, S_SIN1_Z: z2_in = z_shr[14:0];
                  S_SIN0_A5, S_SIN1_A5: t_in = 17'(MUL_P_W'(SIN_A3) - z_shr);
                  S_SIN0_A3, S_SIN1_A3: t_in = 17'(MUL_P_W'(SIN_A1) - z_shr);
                  S_SIN0_A1: s0_in = s_new;
                  S_SIN1_A1: begin
                     if (cfg.mode) begin
                        sn_in  = ext_sin;
                        cs_in  = ext_cos;
                        ang_in = '0;
                     end else begin
                        ang_in = phase_acc_ff[ACC_W-1 -: ANGLE_W];
                        case (phase_acc_ff[ACC_W-1 -: 2])
                           2'd0: begin
                              sn_in = s0s;
                              cs_in = s1s;
                           end
                           2'd1: begin
                              sn_in = s1s;
                              cs_in = -s0s;
                           end
                           2'd2: begin
                              sn_in = -s0s;
                              cs_in = -s1s;
                           end
                           default: begin
                              sn_in = -s1s;
                              cs_in = s0s;
                           end
                        endcase
                     end
                  end
                  S_DV_A, S_QV_A, S_DI_A, S_QI_A: acc_in = prod;
                  S_DV_B: dv_in = sat16(rshr(acc_ff + prod, 15));
                  S_QV_B: qv_in = sat16(rshr(acc_ff - prod, 15));
                  S_DI_B: di_in = sat16(rshr(acc_ff + prod, 15));
                  S_QI_B: qi_in = sat16(rshr(acc_ff - prod, 15));
                  S_OMEGA: omega_in = sat32(rshr(prod, 15) + MUL_P_W'(vd_int_ff));
                  S_INTEG: begin
                     if (cfg.mode && hold_ff) begin
                        vd_int_in = '0;
                     end else begin
                        vd_int_in = sat32(MUL_P_W'(vd_int_ff) + rshr(prod, 23));
                     end
                  end
                  S_LPF: begin
                     if (!cfg.mode) begin
                        freq_filt_in = FREQ_W'(MUL_P_W'(freq_filt_ff) + rshr(prod, 16));
                     end
                  end
                  S_PHASE: begin
                     if (!cfg.mode) begin
                        phase_acc_in = phase_acc_ff + ACC_W'(rshr(prod, 23));
                     end
                     state_in = ST_DONE;
                     step_in  = S_CLK_AV;
                  end
                  default: step_in = S_CLK_AV;
               endcase
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(cfg.mode ? omega_ff : freq_filt_ff), ang_ff,
                               qi_ff, di_ff, qv_ff, dv_ff, cs_ff, sn_ff,
                               bei_ff, ali_ff, bev_ff, alv_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_CLK_AV;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vd_int_ff    <= '0;
         freq_filt_ff <= '0;
         phase_acc_ff <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         vd_int_ff    <= vd_int_in;
         freq_filt_ff <= freq_filt_in;
         phase_acc_ff <= phase_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      hold_ff     <= hold_in;
      alv_ff      <= alv_in;
      bev_ff      <= bev_in;
      ali_ff      <= ali_in;
      bei_ff      <= bei_in;
      sn_ff       <= sn_in;
      cs_ff       <= cs_in;
      dv_ff       <= dv_in;
      qv_ff       <= qv_in;
      di_ff       <= di_in;
      qi_ff       <= qi_in;
      z2_ff       <= z2_in;
      t_ff        <= t_in;
      s0_ff       <= s0_in;
      acc_ff      <= acc_in;
      omega_ff    <= omega_in;
      ang_ff      <= ang_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_phase_only_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |=> $stable(phase_acc_ff))
      else $error("phase accumulator moved outside the sequence");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised without a finished sequence");

   a_idle_step_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (step_ff == S_CLK_AV && !phase_ff))
      else $error("sequencer not parked at first step while idle");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= S_PHASE))
      else $error("sequencer step out of range");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import srfpll_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int LONG_STALL_CYCLES = 3000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int NUM_FIELDS = 12;

   typedef struct packed {
      logic        hold;
      logic [15:0] ext_cos;
      logic [15:0] ext_sin;
      logic [15:0] curr_c;
      logic [15:0] curr_b;
      logic [15:0] curr_a;
      logic [15:0] volt_c;
      logic [15:0] volt_b;
      logic [15:0] volt_a;
   } sample_type;

   class srf_scoreboard;
      logic              mode;
      logic [23:0]       pll_kp, pll_ki_ts, vsg_kp, vsg_ki_ts;
      logic [15:0]       phase_scale, lpf_alpha;
      longint            vd_integral;
      longint            freq_filtered;
      logic [23:0]       phase_acc;
      logic [RSP_DATA_W-1:0] expected_q[$];
      int                errors;
      string             names[NUM_FIELDS];

      function new();
         names = '{"alpha_volt", "beta_volt", "alpha_curr", "beta_curr", "sine_used",
                   "cosine_used", "d_volt", "q_volt", "d_curr", "q_curr", "angle", "freq"};
         mode = 1'b0;
         pll_kp = '0;
         pll_ki_ts = '0;
         phase_scale = '0;
         lpf_alpha = 16'd655;
         vsg_kp = 24'd117965;
         vsg_ki_ts = '0;
         vd_integral = 0;
         freq_filtered = 0;
         phase_acc = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
         case (idx)
            REG_MODE:      mode = val[0];
            REG_PLL_KP:    pll_kp = val;
            REG_PLL_KI_TS: pll_ki_ts = val;
            REG_PHASE_SC:  phase_scale = val[15:0];
            REG_LPF_ALPHA: lpf_alpha = val[15:0];
            REG_VSG_KP:    vsg_kp = val;
            REG_VSG_KI_TS: vsg_ki_ts = val;
            default: ;
         endcase
      endfunction

      // add one half, then floor
      function longint rnd(longint v, int n);
         return (v + (64'sd1 <<< (n - 1))) >>> n;
      endfunction

      function longint clip(longint v, int w);
         longint hi;
         hi = (64'sd1 <<< (w - 1)) - 1;
         return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
      endfunction

      function longint quarter_sine(longint r);
         longint z2, t, y;
         z2 = (r * r) >> 14;
         t = 42048 - ((4640 * z2) >> 14);
         t = 102944 - ((t * z2) >> 14);
         y = (t * r + 16384) >> 15;
         return y > 32767 ? 32767 : y;
      endfunction

      function longint clarke_alpha(logic [15:0] a, logic [15:0] b, logic [15:0] c);
         return clip(rnd((2 * longint'($signed(a)) - longint'($signed(b))
                          - longint'($signed(c))) * 21845, 16), 16);
      endfunction

      function longint clarke_beta(logic [15:0] b, logic [15:0] c);
         return clip(rnd((longint'($signed(b)) - longint'($signed(c))) * 37837, 16), 16);
      endfunction

      function void note_sample(sample_type s);
         longint alv, bev, ali, bei, sn, cs, dv, qv, di, qi, omega, freq, kp, ki, s0, s1, step;
         logic [15:0] u, ang;
         logic [RSP_DATA_W-1:0] r;
         alv = clarke_alpha(s.volt_a, s.volt_b, s.volt_c);
         bev = clarke_beta(s.volt_b, s.volt_c);
         ali = clarke_alpha(s.curr_a, s.curr_b, s.curr_c);
         bei = clarke_beta(s.curr_b, s.curr_c);
         ang = '0;
         if (!mode) begin
            u = phase_acc[23:8];
            s0 = quarter_sine(longint'(u[13:0]));
            s1 = quarter_sine(16384 - longint'(u[13:0]));
            case (u[15:14])
               2'd0: begin sn = s0;  cs = s1;  end
               2'd1: begin sn = s1;  cs = -s0; end
               2'd2: begin sn = -s0; cs = -s1; end
               default: begin sn = -s1; cs = s0; end
            endcase
            ang = u;
            kp = pll_kp;
            ki = pll_ki_ts;
         end else begin
            sn = $signed(s.ext_sin);
            cs = $signed(s.ext_cos);
            kp = vsg_kp;
            ki = vsg_ki_ts;
         end
         dv = clip(rnd(alv * cs + bev * sn, 15), 16);
         qv = clip(rnd(bev * cs - alv * sn, 15), 16);
         di = clip(rnd(ali * cs + bei * sn, 15), 16);
         qi = clip(rnd(bei * cs - ali * sn, 15), 16);
         omega = clip(rnd(kp * dv, 15) + vd_integral, 32);
         if (mode && s.hold)
            vd_integral = 0;
         else
            vd_integral = clip(vd_integral + rnd(dv * ki, 23), 32);
         if (!mode) begin
            freq_filtered += rnd((omega - freq_filtered) * longint'(lpf_alpha), 16);
            step = rnd(omega * longint'(phase_scale), 23);
            phase_acc = phase_acc + step[23:0];
            freq = freq_filtered;
         end else begin
            freq = omega;
         end
         r = {freq[31:0], ang, qi[15:0], di[15:0], qv[15:0], dv[15:0], cs[15:0], sn[15:0],
              bei[15:0], ali[15:0], bev[15:0], alv[15:0]};
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] got);
         logic [RSP_DATA_W-1:0] want;
         logic [31:0] w, g;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = expected_q.pop_front();
         for (int i = 0; i < NUM_FIELDS; i++) begin
            w = (i < 11) ? 32'(want[16*i +: 16]) : want[176 +: 32];
            g = (i < 11) ? 32'(got[16*i +: 16]) : got[176 +: 32];
            if (w !== g) begin
               errors++;
               if (errors <= 10) $display("%s mismatch: expected %h got %h", names[i], w, g);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   srf_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   logic long_stall = 1'b0;
   event start_long_stall;

   srf_pll_clarke_park_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("srf_pll_clarke_park_unit verification failed");
         $finish;
      end
   end

   // take result beats, stall at random or through a long hold-off
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (reset || long_stall)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always begin
      @(start_long_stall);
      @(posedge clock);
      long_stall <= 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clock);
      long_stall <= 1'b0;
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(sample_type s);
      req_tvalid <= 1'b1;
      req_tdata <= s[REQ_DATA_W-1:0];
      req_tuser <= s.hold;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic sample_type mk(int va, int vb, int vc, int ia, int ib, int ic,
                                     int sn, int cs, bit h);
      sample_type s;
      s.volt_a = va[15:0];
      s.volt_b = vb[15:0];
      s.volt_c = vc[15:0];
      s.curr_a = ia[15:0];
      s.curr_b = ib[15:0];
      s.curr_c = ic[15:0];
      s.ext_sin = sn[15:0];
      s.ext_cos = cs[15:0];
      s.hold = h;
      return s;
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(3))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   // mostly balanced three-phase sets, some raw noise and extremes
   function automatic sample_type rand_sample();
      sample_type s;
      int a, b;
      int kind;
      s = sample_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      kind = $urandom_range(9);
      if (kind < 7) begin
         a = $urandom_range(0, 32767) - 16384;
         b = $urandom_range(0, 32767) - 16384;
         s.volt_a = a[15:0];
         s.volt_b = b[15:0];
         s.volt_c = 16'(-(a + b));
         a = $urandom_range(0, 32767) - 16384;
         b = $urandom_range(0, 32767) - 16384;
         s.curr_a = a[15:0];
         s.curr_b = b[15:0];
         s.curr_c = 16'(-(a + b));
      end else if (kind == 8) begin
         s.volt_a = pick_extreme();
         s.volt_b = pick_extreme();
         s.volt_c = pick_extreme();
         s.curr_a = pick_extreme();
         s.curr_b = pick_extreme();
         s.curr_c = pick_extreme();
         s.ext_sin = pick_extreme();
         s.ext_cos = pick_extreme();
      end
      s.hold = ($urandom_range(3) == 0);
      return s;
   endfunction

   task automatic configure(int ph);
      logic [23:0] v[7];
      case (ph)
         0: v = '{24'd0, 24'hffffff, 24'hffffff, 24'hffff, 24'hffff, 24'd0, 24'd0};
         1: v = '{24'hffffff, 24'd0, 24'd0, 24'd0, 24'd655, 24'hffffff, 24'hffffff};
         2: v = '{24'hfffffe, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
         3: v = '{24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
         default: begin
            v[0] = 24'(ph & 1);
            for (int i = 1; i < 7; i++) v[i] = 24'($urandom);
            v[1] = 24'($urandom_range(0, 24'h3ffff));
            v[2] = 24'($urandom_range(0, 24'h1fff));
         end
      endcase
      write_reg(REG_MODE, v[0]);
      write_reg(REG_PLL_KP, v[1]);
      write_reg(REG_PLL_KI_TS, v[2]);
      write_reg(REG_PHASE_SC, v[3]);
      write_reg(REG_LPF_ALPHA, v[4]);
      write_reg(REG_VSG_KP, v[5]);
      write_reg(REG_VSG_KI_TS, v[6]);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, PLL mode: sample extremes, hold ignored
      send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 1));
      send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0));
      send_sample(mk(32767, -32768, -32768, -32768, 32767, 32767, 0, 0, 1));
      send_sample(mk(-32768, 32767, 32767, 32767, -32768, -32768, 0, 0, 0));
      send_sample(mk(0, 32767, -32768, 0, -32768, 32767, 0, 0, 0));
      send_sample(mk(0, -32768, 32767, 0, 32767, -32768, 0, 0, 1));
      send_sample(mk(-1, -1, -1, 1, 1, 1, 0, 0, 0));
      send_sample(mk(20000, -10000, -10000, 5000, -2500, -2500, 0, 0, 0));
      drain();
      // out-of-range index must be dropped
      write_reg(REG_UNUSED, 24'hffffff);
      write_reg(REG_VSG_KI_TS, 24'h100000);
      write_reg(REG_MODE, 24'd1);
      send_sample(mk(32767, -32768, -32768, 32767, 0, 0, 32767, 0, 0));
      send_sample(mk(32767, -32768, -32768, 32767, 0, 0, -32768, -32768, 0));
      send_sample(mk(-32768, 32767, 32767, -32768, 32767, 32767, 32767, 32767, 0));
      send_sample(mk(10000, 0, -10000, 10000, 0, -10000, 0, 32767, 1));
      send_sample(mk(10000, 0, -10000, 10000, 0, -10000, -32768, 0, 0));
      send_sample(mk(10000, 0, -10000, 10000, 0, -10000, 23170, 23170, 0));
      send_sample(mk(32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767, 1));
      send_sample(mk(0, 0, 0, 0, 0, 0, 32767, -32768, 0));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         configure(ph);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         if (ph == 4) -> start_long_stall;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(rand_sample());
         drain();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("srf_pll_clarke_park_unit verification clean");
      else
         $display("srf_pll_clarke_park_unit verification failed");
      $finish;
   end

endmodule
